// File: sv/cpc_pkg.sv
// shared types and constants for the convex polygon point containment block
package cpc_pkg;

    localparam int CoordW   = 24;
    localparam int HeightW  = 24;
    localparam int SlotW    = 4;
    localparam int EdgeCntW = 5;
    localparam int HtolW    = 16;
    localparam int CtolW    = 24;
    localparam int CfgDataW = 24;
    localparam int CfgIdxW  = 3;
    localparam int StatusW  = 2;

    localparam logic [CfgIdxW-1:0] CfgMinHeight = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgMaxHeight = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgEdgeCount = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgHeightTol = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgCrossTol  = 3'd4;

    localparam logic [HeightW-1:0]  RstMinHeight = 24'd0;
    localparam logic [HeightW-1:0]  RstMaxHeight = 24'd0;
    localparam logic [EdgeCntW-1:0] RstEdgeCount = 5'd3;
    localparam logic [HtolW-1:0]    RstHeightTol = 16'd26;
    localparam logic [CtolW-1:0]    RstCrossTol  = 24'd655;

    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdQuery = 1'b1;

    localparam logic [StatusW-1:0] StInside  = 2'd0;
    localparam logic [StatusW-1:0] StBelow   = 2'd1;
    localparam logic [StatusW-1:0] StAbove   = 2'd2;
    localparam logic [StatusW-1:0] StOutside = 2'd3;

    typedef struct packed {
        logic                     cmd;
        logic [SlotW-1:0]         vertex_slot;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_z;
        logic signed [CoordW-1:0] query_height;
    } in_req_t;

    typedef struct packed {
        logic               inside_res;
        logic [StatusW-1:0] status;
    } out_req_t;

    typedef struct packed {
        logic               wr_en;
        logic               capture;
        logic               rd_en;
        logic               rd_first;
        logic               rd_last;
        logic               flush;
        logic               res_load;
        logic [StatusW-1:0] res_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic below;
        logic above;
        logic edge_fail;
        logic edge_pass;
    } dp_status_t;

endpackage

// File: sv/convex_polygon_point_containment_top.sv
// top level of the convex polygon point containment block
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  cpc_pkg::in_req_t  (load vertex or query point)
//   m_        out        m_valid / m_ready  cpc_pkg::out_req_t (one per query)
//   cfg_      in         cfg_we             cfg_idx, cfg_data
//
// loads are taken in idle, so they stream at one per cycle while no query is in progress
// a query out of the height band goes straight to its result; else it walks the clamped
// edge count, one edge per cycle through the read and difference stages and the shared pair
// of multipliers into the product stage; the walk ends early at the first failing edge
// synchronous active-low reset; the vertex store is not cleared
// a result waits in the output register while the next request is taken; a query
// only stalls at its end when the previous result is still held
module convex_polygon_point_containment_top #(
    parameter int MAX_EDGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [cpc_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [cpc_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  cpc_pkg::in_req_t             s_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cpc_pkg::out_req_t            m_req
);

    localparam int AW = $clog2(MAX_EDGES);

    cpc_pkg::ctrl_cmd_t  ctl;
    cpc_pkg::dp_status_t sts;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       last_idx;

    cpc_ctrl #(
        .MAX_EDGES (MAX_EDGES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_req.cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .last_idx (last_idx),
        .rd_addr  (rd_addr),
        .ctl      (ctl),
        .sts      (sts)
    );

    cpc_dp #(
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_req    (s_req),
        .m_req    (m_req),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .last_idx (last_idx),
        .sts      (sts)
    );

endmodule

// File: sv/cpc_ram.sv
// generic single write port, single read port ram with registered read
module cpc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cpc_ctrl.sv
// controller state machine: request handshake, edge walk sequencing, result handoff
module cpc_ctrl #(
    parameter int MAX_EDGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  logic [$clog2(MAX_EDGES)-1:0] last_idx,
    output logic [$clog2(MAX_EDGES)-1:0] rd_addr,
    output cpc_pkg::ctrl_cmd_t           ctl,
    input  cpc_pkg::dp_status_t          sts
);

    localparam int AW = $clog2(MAX_EDGES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HGT   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RES   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    logic [cpc_pkg::StatusW-1:0]   status_reg, status_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          accept;
    logic                          at_last;

    assign accept  = s_valid && s_ready;
    assign at_last = (cnt_reg == last_idx);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        ctl            = '0;
        ctl.res_status = status_reg;
        s_ready        = 1'b0;
        rd_addr        = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_cmd == cpc_pkg::CmdQuery) begin
                        ctl.capture = 1'b1;
                        state_next  = S_HGT;
                    end else begin
                        ctl.wr_en = 1'b1;
                    end
                end
            end
            S_HGT: begin
                rd_addr = last_idx;
                if (sts.below) begin
                    status_next = cpc_pkg::StBelow;
                    state_next  = S_RES;
                end else if (sts.above) begin
                    status_next = cpc_pkg::StAbove;
                    state_next  = S_RES;
                end else begin
                    ctl.rd_en    = 1'b1;
                    ctl.rd_first = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_WALK;
                end
            end
            S_WALK: begin
                if (sts.edge_fail) begin
                    ctl.flush   = 1'b1;
                    status_next = cpc_pkg::StOutside;
                    state_next  = S_RES;
                end else begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_last = at_last;
                    if (at_last) begin
                        state_next = S_DRAIN;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (sts.edge_fail) begin
                    ctl.flush   = 1'b1;
                    status_next = cpc_pkg::StOutside;
                    state_next  = S_RES;
                end else if (sts.edge_pass) begin
                    ctl.flush   = 1'b1;
                    status_next = cpc_pkg::StInside;
                    state_next  = S_RES;
                end
            end
            S_RES: begin
                if (!out_valid_reg || m_ready) begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.res_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            status_reg    <= cpc_pkg::StInside;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: sv/cpc_dp.sv
// datapath: config registers, vertex store, height check, cross product pipeline, result register
module cpc_dp #(
    parameter int MAX_EDGES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cpc_pkg::CfgIdxW-1:0]    cfg_idx,
    input  logic [cpc_pkg::CfgDataW-1:0]   cfg_data,
    input  cpc_pkg::in_req_t               s_req,
    output cpc_pkg::out_req_t              m_req,
    input  cpc_pkg::ctrl_cmd_t             ctl,
    input  logic [$clog2(MAX_EDGES)-1:0]   rd_addr,
    output logic [$clog2(MAX_EDGES)-1:0]   last_idx,
    output cpc_pkg::dp_status_t            sts
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = cpc_pkg::CoordW;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int HW = CW + 2;

    // configuration
    logic signed [cpc_pkg::HeightW-1:0] min_height_reg;
    logic signed [cpc_pkg::HeightW-1:0] max_height_reg;
    logic [cpc_pkg::EdgeCntW-1:0]       edge_count_reg;
    logic [cpc_pkg::HtolW-1:0]          height_tol_reg;
    logic [cpc_pkg::CtolW-1:0]          cross_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_height_reg <= cpc_pkg::RstMinHeight;
            max_height_reg <= cpc_pkg::RstMaxHeight;
            edge_count_reg <= cpc_pkg::RstEdgeCount;
            height_tol_reg <= cpc_pkg::RstHeightTol;
            cross_tol_reg  <= cpc_pkg::RstCrossTol;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                cpc_pkg::CfgMinHeight: min_height_reg <= cfg_data[cpc_pkg::HeightW-1:0];
                cpc_pkg::CfgMaxHeight: max_height_reg <= cfg_data[cpc_pkg::HeightW-1:0];
                cpc_pkg::CfgEdgeCount: edge_count_reg <= cfg_data[cpc_pkg::EdgeCntW-1:0];
                cpc_pkg::CfgHeightTol: height_tol_reg <= cfg_data[cpc_pkg::HtolW-1:0];
                cpc_pkg::CfgCrossTol:  cross_tol_reg  <= cfg_data[cpc_pkg::CtolW-1:0];
                default: ;
            endcase
        end
    end

    // clamped vertex count
    int n_edges;
    always_comb begin
        if (32'(edge_count_reg) < 3) begin
            n_edges = 3;
        end else if (32'(edge_count_reg) > MAX_EDGES) begin
            n_edges = MAX_EDGES;
        end else begin
            n_edges = 32'(edge_count_reg);
        end
        last_idx = AW'(n_edges - 1);
    end

    // vertex store
    logic          slot_ok;
    logic          ram_we;
    logic [PW-3:0] ram_rdata;

    assign slot_ok = (32'(s_req.vertex_slot) < MAX_EDGES);
    assign ram_we  = ctl.wr_en && slot_ok;

    cpc_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_EDGES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_req.vertex_slot)),
        .wdata ({s_req.coord_x, s_req.coord_z}),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // query point
    logic signed [CW-1:0] px_reg, pz_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            px_reg <= s_req.coord_x;
            pz_reg <= s_req.coord_z;
            py_reg <= s_req.query_height;
        end
    end

    // height band check
    logic signed [HW-1:0] band_lo, band_hi, py_ext;
    logic                 hgt_below, hgt_above;

    always_comb begin
        py_ext  = {{2{py_reg[CW-1]}}, py_reg};
        band_lo = {{2{min_height_reg[CW-1]}}, min_height_reg}
                - {{(HW - cpc_pkg::HtolW){1'b0}}, height_tol_reg};
        band_hi = {{2{max_height_reg[CW-1]}}, max_height_reg}
                + {{(HW - cpc_pkg::HtolW){1'b0}}, height_tol_reg};
        hgt_below = (py_ext < band_lo);
        hgt_above = (py_ext > band_hi);
    end

    // read stage tags and previous vertex
    logic                 rv_reg, rfirst_reg, rlast_reg;
    logic signed [CW-1:0] vx, vz;
    logic signed [CW-1:0] lx_reg, lz_reg;

    assign vx = ram_rdata[2*CW-1:CW];
    assign vz = ram_rdata[CW-1:0];

    // difference stage
    logic                 dv_reg, dlast_reg;
    logic signed [DW-1:0] u_reg, v_reg, xd_reg, zd_reg;

    // product stage
    logic                 pv_reg, plast_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [PW-1:0] p1_next, p2_next;

    assign p1_next = xd_reg * v_reg;
    assign p2_next = zd_reg * u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
            dv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else if (ctl.flush) begin
            rv_reg <= 1'b0;
            dv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else begin
            rv_reg <= ctl.rd_en;
            dv_reg <= rv_reg && !rfirst_reg;
            pv_reg <= dv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rfirst_reg <= ctl.rd_first;
        rlast_reg  <= ctl.rd_last;
        dlast_reg  <= rlast_reg;
        plast_reg  <= dlast_reg;
        if (rv_reg) begin
            lx_reg <= vx;
            lz_reg <= vz;
            u_reg  <= {vx[CW-1], vx} - {lx_reg[CW-1], lx_reg};
            v_reg  <= {vz[CW-1], vz} - {lz_reg[CW-1], lz_reg};
            xd_reg <= {px_reg[CW-1], px_reg} - {lx_reg[CW-1], lx_reg};
            zd_reg <= {pz_reg[CW-1], pz_reg} - {lz_reg[CW-1], lz_reg};
        end
        p1_reg <= p1_next;
        p2_reg <= p2_next;
    end

    // cross product plus slack, outside when not positive
    logic signed [SW-1:0] cross_sum;
    logic                 cross_fail;

    always_comb begin
        cross_sum = {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg}
                  + {{(SW - cpc_pkg::CtolW){1'b0}}, cross_tol_reg};
        cross_fail    = cross_sum[SW-1] || (cross_sum == '0);
        sts.below     = hgt_below;
        sts.above     = hgt_above;
        sts.edge_fail = pv_reg && cross_fail;
        sts.edge_pass = pv_reg && plast_reg && !cross_fail;
    end

    // result register
    cpc_pkg::out_req_t res_reg;

    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            res_reg.status     <= ctl.res_status;
            res_reg.inside_res <= (ctl.res_status == cpc_pkg::StInside);
        end
    end

    assign m_req = res_reg;

endmodule

// File: sv/cpc_checker.sv
// port-level checker for the convex polygon point containment block, with its bind
module cpc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input cpc_pkg::in_req_t  s_req,
    input logic              m_valid,
    input logic              m_ready,
    input cpc_pkg::out_req_t m_req
);

    // held result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_req))
        else $error("result changed while stalled");

    // a query request occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req.cmd == cpc_pkg::CmdQuery |=> !s_ready)
        else $error("request taken right after a query");

    // loads stream without a gap
    a_load_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req.cmd == cpc_pkg::CmdLoad |=> s_ready)
        else $error("ready dropped after a load");

    // inside flag agrees with status
    a_inside_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_req.inside_res == (m_req.status == cpc_pkg::StInside)))
        else $error("inside flag and status disagree");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind convex_polygon_point_containment_top cpc_checker u_cpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_req   (m_req)
);
